/* hdl/hermite_fractional_delay_line_core_assert.svh */
// Assertion macros used by the Hermite delay line back part (hfd_back).
`ifndef HERMITE_FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH
`define HERMITE_FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/hfd_pkg.sv */
// Package with the shared types and constants of the Hermite delay line.
`timescale 1ns / 1ps
package hfd_pkg;

   // Field widths of the transactions.
   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 33;
   localparam int MOD_W    = 16;
   localparam int FRAC_W   = 16;

   // Modulated delay: D + round(D*m / 3276800). Since 3276800 = 25 * 2^17 the
   // division is an arithmetic shift by 17 followed by a divide by 25, done as
   // a multiply by a reciprocal on a value offset to be non-negative.
   localparam int                 MOD_PROD_W      = 50;
   localparam logic signed [49:0] MOD_ROUND       = 50'sd1638400;
   localparam int                 DIV_IN_W        = 32;
   localparam logic signed [32:0] DIV_OFFSET      = 33'sd2147483650;
   localparam logic [30:0]        DIV_MAGIC       = 31'h51EB851F;
   localparam int                 DIV_PROD_W      = 63;
   localparam int                 DIV_MAGIC_SHIFT = 35;
   localparam int                 QUOT_W          = 28;
   localparam logic signed [28:0] DIV_OFFSET_QUOT = 29'sd85899346;
   localparam int                 DELAY_FULL_W    = 37;

   // Hermite datapath widths.
   localparam int C1_W = 26;
   localparam int C2_W = 28;
   localparam int C3_W = 28;
   localparam int A1_W = 45;
   localparam int A2_W = 62;
   localparam int A3_W = 46;
   localparam int A4_W = 64;
   localparam int RES_W = 31;
   localparam logic signed [63:0] RESULT_ROUND = 64'sd4294967296;

   localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

   // Four taps per item, read one per cycle.
   localparam int         TAP_W    = 2;
   localparam logic [1:0] TAP_Y0   = 2'd0;
   localparam logic [1:0] TAP_Y1   = 2'd1;
   localparam logic [1:0] TAP_Y2   = 2'd2;
   localparam logic [1:0] TAP_LAST = 2'd3;

   // Items between the start of their reads and the taken response.
   localparam int         INFLIGHT_W   = 3;
   localparam logic [2:0] MAX_INFLIGHT = 3'd4;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MUL,
      FR_DIV,
      FR_PUSH
   } hfd_front_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ
   } hfd_back_state_type;

endpackage

/* hdl/hfd_if.sv */
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps
interface hfd_req_if;
   import hfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] write_sample;
   logic        [DELAY_W-1:0]  delay_time;
   logic signed [MOD_W-1:0]    mod_amount;

   modport source (output valid, output write_sample, output delay_time,
                   output mod_amount, input ready);
   modport sink   (input valid, input write_sample, input delay_time,
                   input mod_amount, output ready);
endinterface

interface hfd_rsp_if;
   import hfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] delayed_sample;

   modport source (output valid, output delayed_sample, input ready);
   modport sink   (input valid, input delayed_sample, output ready);
endinterface

/* hdl/hfd_front.sv */
// Front part: accepts a request, computes the modulated delay and read position.
`timescale 1ns / 1ps
module hfd_front #(
   parameter int STORE_DEPTH_LOG2 = 17
) (
   input  logic clock,
   input  logic reset,
   hfd_req_if.sink req_chan,
   input  logic clearing,
   output logic push_valid,
   input  logic push_ready,
   output logic [hfd_pkg::SAMPLE_W+2*STORE_DEPTH_LOG2+hfd_pkg::FRAC_W-1:0] push_data
);
   import hfd_pkg::*;

   localparam int POS_W = STORE_DEPTH_LOG2 + FRAC_W;
   localparam logic [POS_W-1:0] DELAY_LO = POS_W'(1) << FRAC_W;
   localparam logic [POS_W-1:0] DELAY_HI = {{STORE_DEPTH_LOG2{1'b1}}, {FRAC_W{1'b0}}};

   hfd_front_state_type state_ff, state_in;

   logic        [DELAY_W-1:0]          d_ff, d_in;
   logic signed [MOD_W-1:0]            m_ff, m_in;
   logic        [SAMPLE_W-1:0]         samp_ff, samp_in;
   logic signed [MOD_PROD_W-1:0]       prod_ff, prod_in;
   logic        [QUOT_W-1:0]           quot_ff, quot_in;
   logic        [STORE_DEPTH_LOG2-1:0] wi_ff, wi_in;

   logic signed [MOD_PROD_W-1:0]   mul_prod;
   logic signed [MOD_PROD_W-1:0]   rnd_sum;
   logic signed [DIV_IN_W-1:0]     shifted;
   logic signed [DIV_IN_W:0]       biased;
   logic        [DIV_PROD_W-1:0]   div_prod;
   logic signed [QUOT_W:0]         quot_s;
   logic signed [DELAY_FULL_W-1:0] delay_full;
   logic        [POS_W-1:0]        delay_c;
   logic        [POS_W-1:0]        pos;

   // D * m, signed.
   assign mul_prod = $signed({1'b0, d_ff}) * m_ff;

   // Round, divide by 2^17 (floor), then offset so the divide by 25 sees a
   // non-negative value below 2^32.
   assign rnd_sum  = prod_ff + MOD_ROUND;
   assign shifted  = $signed(rnd_sum[DIV_IN_W+16:17]);
   assign biased   = (DIV_IN_W+1)'(shifted) + DIV_OFFSET;
   assign div_prod = biased[DIV_IN_W-1:0] * DIV_MAGIC;

   assign quot_s     = $signed({1'b0, quot_ff}) - DIV_OFFSET_QUOT;
   assign delay_full = $signed({{(DELAY_FULL_W-DELAY_W){1'b0}}, d_ff})
                       + DELAY_FULL_W'(quot_s);

   always_comb begin
      if (delay_full < $signed(DELAY_FULL_W'(DELAY_LO))) begin
         delay_c = DELAY_LO;
      end else if (delay_full > $signed(DELAY_FULL_W'(DELAY_HI))) begin
         delay_c = DELAY_HI;
      end else begin
         delay_c = delay_full[POS_W-1:0];
      end
   end

   // The subtraction wraps modulo the ring size in fixed point.
   assign pos       = {wi_ff, {FRAC_W{1'b0}}} - delay_c;
   assign push_data = {samp_ff, wi_ff, pos};

   always_comb begin
      state_in       = state_ff;
      d_in           = d_ff;
      m_in           = m_ff;
      samp_in        = samp_ff;
      prod_in        = prod_ff;
      quot_in        = quot_ff;
      wi_in          = wi_ff;
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_chan.ready = !clearing;
            if (req_chan.valid && !clearing) begin
               d_in     = req_chan.delay_time;
               m_in     = req_chan.mod_amount;
               samp_in  = req_chan.write_sample;
               state_in = FR_MUL;
            end
         end
         FR_MUL: begin
            prod_in  = mul_prod;
            state_in = FR_DIV;
         end
         FR_DIV: begin
            quot_in  = div_prod[DIV_PROD_W-1:DIV_MAGIC_SHIFT];
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               wi_in    = wi_ff + STORE_DEPTH_LOG2'(1);
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         wi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wi_ff    <= wi_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      m_ff    <= m_in;
      samp_ff <= samp_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
   end

endmodule

/* hdl/hfd_queue.sv */
// Two-entry queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module hfd_queue #(
   parameter int DATA_WIDTH = 74
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_data
);
   import hfd_pkg::*;

   logic [DATA_WIDTH-1:0]  ent_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wp_ff, wp_in;
   logic [QUEUE_PTR_W-1:0] rp_ff, rp_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   push, pop;

   assign in_ready  = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = ent_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? wp_ff + QUEUE_PTR_W'(1) : wp_ff;
      rp_in  = pop ? rp_ff + QUEUE_PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + QUEUE_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - QUEUE_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= in_data;
      end
   end

endmodule

/* hdl/hfd_back.sv */
// Back part: sample store, tap reads, Hermite interpolation and response register.
`timescale 1ns / 1ps
`include "hermite_fractional_delay_line_core_assert.svh"
module hfd_back #(
   parameter int STORE_DEPTH_LOG2 = 17
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [hfd_pkg::SAMPLE_W+2*STORE_DEPTH_LOG2+hfd_pkg::FRAC_W-1:0] pop_data,
   output logic clearing,
   hfd_rsp_if.source rsp_chan
);
   import hfd_pkg::*;

   localparam int DL          = STORE_DEPTH_LOG2;
   localparam int STORE_DEPTH = 1 << DL;

   // Sample store, one write port and one registered read port.
   logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_we;
   logic [DL-1:0]       mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic [DL-1:0]       mem_raddr;

   // Tap sequencer.
   hfd_back_state_type    state_ff, state_in;
   logic [TAP_W-1:0]      step_ff, step_in;
   logic [DL-1:0]         clr_ff, clr_in;
   logic [DL-1:0]         ip_ff, ip_in;
   logic [FRAC_W-1:0]     f_ff, f_in;
   logic [SAMPLE_W-1:0]   ws_ff, ws_in;
   logic [DL-1:0]         wa_ff, wa_in;
   logic [INFLIGHT_W-1:0] inflight_ff, inflight_in;
   logic                  rd_issue;
   logic                  start_ok;
   logic                  pop_take;
   logic                  rsp_take;

   // Tap gathering.
   logic                       rd_valid_ff;
   logic [TAP_W-1:0]           rd_tap_ff;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic signed [SAMPLE_W-1:0] y0_ff, y1_ff, y2_ff;
   logic [FRAC_W-1:0]          gf_ff;
   logic                       gather_last;

   // Interpolation pipeline.
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [C1_W-1:0]     s1_c1_ff, s1_c1_in;
   logic signed [C2_W-1:0]     s1_c2_ff, s1_c2_in;
   logic signed [C3_W-1:0]     s1_c3_ff, s1_c3_in;
   logic signed [SAMPLE_W-1:0] s1_y1_ff;
   logic [FRAC_W-1:0]          s1_f_ff;
   logic signed [C3_W-1:0]     d12;

   logic                       s2_valid_ff, s2_valid_in;
   logic signed [A1_W-1:0]     s2_a1_ff, s2_a1_in;
   logic signed [C1_W-1:0]     s2_c1_ff;
   logic signed [SAMPLE_W-1:0] s2_y1_ff;
   logic [FRAC_W-1:0]          s2_f_ff;

   logic                       s3_valid_ff, s3_valid_in;
   logic signed [A3_W-1:0]     s3_a3_ff, s3_a3_in;
   logic signed [A2_W-1:0]     a2;
   logic signed [SAMPLE_W-1:0] s3_y1_ff;
   logic [FRAC_W-1:0]          s3_f_ff;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_data_ff, out_data_in;
   logic signed [A4_W-1:0]     a4;
   logic signed [RES_W-1:0]    res;

   logic s2_load, s3_load, out_load;

   // ---------------- Tap sequencer ----------------

   assign start_ok  = pop_valid && (inflight_ff < MAX_INFLIGHT);
   assign rsp_take  = out_valid_ff && rsp_chan.ready;
   assign mem_raddr = ip_ff + DL'(step_ff) - DL'(1);
   assign clearing  = (state_ff == BK_CLEAR);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      clr_in    = clr_ff;
      ip_in     = ip_ff;
      f_in      = f_ff;
      ws_in     = ws_ff;
      wa_in     = wa_ff;
      pop_take  = 1'b0;
      rd_issue  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wa_ff;
      mem_wdata = ws_ff;
      case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + DL'(1);
            if (&clr_ff) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (start_ok) begin
               pop_take = 1'b1;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            rd_issue = 1'b1;
            step_in  = step_ff + TAP_W'(1);
            if (step_ff == TAP_LAST) begin
               // The new sample goes in while the last tap is read; the
               // read returns the old contents if both address the same slot.
               mem_we = 1'b1;
               if (start_ok) begin
                  pop_take = 1'b1;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (pop_take) begin
         step_in = TAP_Y0;
         f_in    = pop_data[FRAC_W-1:0];
         ip_in   = pop_data[DL+FRAC_W-1:FRAC_W];
         wa_in   = pop_data[2*DL+FRAC_W-1:DL+FRAC_W];
         ws_in   = pop_data[SAMPLE_W+2*DL+FRAC_W-1:2*DL+FRAC_W];
      end
   end

   assign pop_ready = pop_take;

   always_comb begin
      case ({pop_take, rsp_take})
         2'b10:   inflight_in = inflight_ff + INFLIGHT_W'(1);
         2'b01:   inflight_in = inflight_ff - INFLIGHT_W'(1);
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         step_ff     <= TAP_Y0;
         clr_ff      <= '0;
         inflight_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         clr_ff      <= clr_in;
         inflight_ff <= inflight_in;
         rd_valid_ff <= rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff     <= ip_in;
      f_ff      <= f_in;
      ws_ff     <= ws_in;
      wa_ff     <= wa_in;
      rd_tap_ff <= step_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   // ---------------- Tap gathering ----------------

   assign rd_sample   = $signed(rd_data_ff);
   assign gather_last = rd_valid_ff && (rd_tap_ff == TAP_LAST);

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         case (rd_tap_ff)
            TAP_Y0: begin
               y0_ff <= rd_sample;
               gf_ff <= f_ff;
            end
            TAP_Y1: y1_ff <= rd_sample;
            TAP_Y2: y2_ff <= rd_sample;
            default: y0_ff <= y0_ff;
         endcase
      end
   end

   // ---------------- Interpolation pipeline ----------------

   // Doubled Catmull-Rom coefficients; the fourth tap comes straight from
   // the read register.
   assign d12      = C3_W'(y1_ff) - C3_W'(y2_ff);
   assign s1_c1_in = C1_W'(y2_ff) - C1_W'(y0_ff);
   assign s1_c2_in = (C2_W'(y0_ff) <<< 1) - ((C2_W'(y1_ff) <<< 2) + C2_W'(y1_ff))
                     + (C2_W'(y2_ff) <<< 2) - C2_W'(rd_sample);
   assign s1_c3_in = C3_W'(rd_sample) - C3_W'(y0_ff) + (d12 <<< 1) + d12;

   assign s2_a1_in = (A1_W'(s1_c2_ff) <<< FRAC_W)
                     + A1_W'(s1_c3_ff) * A1_W'($signed({1'b0, s1_f_ff}));
   assign a2       = (A2_W'(s2_c1_ff) <<< 32)
                     + A2_W'(s2_a1_ff) * A2_W'($signed({1'b0, s2_f_ff}));
   assign s3_a3_in = $signed(a2[A2_W-1:FRAC_W]);
   assign a4       = (A4_W'(s3_y1_ff) <<< 33)
                     + A4_W'(s3_a3_ff) * A4_W'($signed({1'b0, s3_f_ff})) + RESULT_ROUND;
   assign res      = $signed(a4[A4_W-1:33]);

   always_comb begin
      if (res > RES_W'(SAMPLE_MAX)) begin
         out_data_in = SAMPLE_MAX;
      end else if (res < RES_W'(SAMPLE_MIN)) begin
         out_data_in = SAMPLE_MIN;
      end else begin
         out_data_in = res[SAMPLE_W-1:0];
      end
   end

   // Each stage moves forward when the next one is empty or moving.
   assign out_load = s3_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s3_load  = s2_valid_ff && (!s3_valid_ff || out_load);
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || s3_load);

   assign s1_valid_in  = gather_last || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !s3_load);
   assign s3_valid_in  = s3_load || (s3_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gather_last) begin
         s1_c1_ff <= s1_c1_in;
         s1_c2_ff <= s1_c2_in;
         s1_c3_ff <= s1_c3_in;
         s1_y1_ff <= y1_ff;
         s1_f_ff  <= gf_ff;
      end
      if (s2_load) begin
         s2_a1_ff <= s2_a1_in;
         s2_c1_ff <= s1_c1_ff;
         s2_y1_ff <= s1_y1_ff;
         s2_f_ff  <= s1_f_ff;
      end
      if (s3_load) begin
         s3_a3_ff <= s3_a3_in;
         s3_y1_ff <= s2_y1_ff;
         s3_f_ff  <= s2_f_ff;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.delayed_sample = out_data_ff;

   // ---------------- Assertions ----------------

   `HFD_ASSERT_NOW(a_gather_has_room, clock, reset, gather_last, !s1_valid_ff || s2_load, "first interpolation stage busy when the last tap arrived")
   `HFD_ASSERT_NOW(a_inflight_bound, clock, reset, 1'b1, inflight_ff <= MAX_INFLIGHT, "in-flight count exceeds the pipeline slots")
   `HFD_ASSERT_NOW(a_clear_is_quiet, clock, reset, state_ff == BK_CLEAR, inflight_ff == '0 && !out_valid_ff, "transaction in flight during the clearing pass")
   `HFD_ASSERT_NEXT(a_start_counted, clock, reset, pop_take, inflight_ff != '0, "started item not counted as in flight")

endmodule

/* hdl/hermite_fractional_delay_line_core.sv */
// Top level of the fractional delay line with 4-point cubic Hermite interpolation.
// Each request transaction carries a Q1.23 sample to store, a delay in samples
// with 16 fraction bits and a Q1.15 modulation value; each request produces
// exactly one response transaction with the interpolated, saturated Q1.23
// sample read from the ring before the new sample is written. The ring holds
// 2^STORE_DEPTH_LOG2 samples. After reset the block runs a clearing pass that
// zeroes the ring one entry a cycle; req_chan.ready stays low during the pass.
// After that the four taps of an item come from the single read port of the
// sample store, one per cycle; the back part takes the next item from the queue
// while it reads the last tap of the current one, as long as fewer than four
// items are in flight. The front part steps through accept, multiply, divide
// and push for each item and takes no new request until the queue has taken
// the last one. A response waiting in the output register does not stop new
// requests from being accepted until four items are in flight and the queue fills.
`timescale 1ns / 1ps
module hermite_fractional_delay_line_core #(
   parameter int STORE_DEPTH_LOG2 = 17
) (
   input  logic clock,
   input  logic reset,
   hfd_req_if.sink   req_chan,
   hfd_rsp_if.source rsp_chan
);
   import hfd_pkg::*;

   // A queue entry holds the sample to write, its write address and the
   // fixed-point read position (integer part and 16 fraction bits).
   localparam int ENTRY_W = SAMPLE_W + 2 * STORE_DEPTH_LOG2 + FRAC_W;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   logic               clearing;

   // The front part takes a request, scales and clamps the delay and forms
   // the read position against the write index it keeps.
   hfd_front #(
      .STORE_DEPTH_LOG2(STORE_DEPTH_LOG2)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the front part compute the next position while the back
   // part is still reading taps for the previous one.
   hfd_queue #(
      .DATA_WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // The back part owns the sample store: it reads the four taps, writes the
   // new sample together with the last tap read, runs the interpolation
   // pipeline and holds the response until it is taken.
   hfd_back #(
      .STORE_DEPTH_LOG2(STORE_DEPTH_LOG2)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .clearing  (clearing),
      .rsp_chan  (rsp_chan)
   );

endmodule
